// ----- hw/rtl/event_loop_recorder_defines.svh -----
// Assertion macros for the event loop recorder RTL.
// Included by elr_back, the module that carries concurrent assertions; no other dependencies.
`ifndef EVENT_LOOP_RECORDER_DEFINES_SVH
`define EVENT_LOOP_RECORDER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted.
`define ELR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define ELR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ELR_ASSERT(label, clk, rst_n, prop, msg)
`define ELR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/elr_pkg.sv -----
// Shared types, codes and helpers for the event loop recorder.
// No dependencies; used by every module of the block.
`default_nettype none

package elr_pkg;

  localparam int unsigned EventDepth = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_RECORD     = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_CLEAR_LANE = 2'd2,
    CMD_CLEAR_ALL  = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_ARMED = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Operation handed from the front end to the execution engine.
  typedef enum logic [2:0] {
    OP_RECORD     = 3'd0,
    OP_REJECT     = 3'd1,
    OP_TICK       = 3'd2,
    OP_CLEAR_LANE = 3'd3,
    OP_CLEAR_ALL  = 3'd4
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] position;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [14:0] pitch;
    logic [2:0]  volume;
    logic [11:0] duration;
    logic [2:0]  aux;
    logic [2:0]  lane;
  } in_t;

  typedef struct packed {
    logic        is_event;
    logic [1:0]  out_kind;
    logic [3:0]  out_slot;
    logic [14:0] out_pitch;
    logic [2:0]  out_volume;
    logic [11:0] out_duration;
    logic [2:0]  out_aux;
    logic [2:0]  out_lane;
    logic [1:0]  status;
    logic [6:0]  stored_count;
    logic        last;
  } out_t;

  // One stored event, 57 bits.
  typedef struct packed {
    logic [14:0] pos;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [14:0] pitch;
    logic [2:0]  volume;
    logic [11:0] duration;
    logic [2:0]  aux;
    logic [2:0]  lane;
  } event_t;

  typedef struct packed {
    op_e    op;
    event_t evt;
  } cmd_t;

  function automatic out_t mk_result(input logic is_ev, input event_t e,
                                     input status_e st, input logic [6:0] cnt,
                                     input logic lst);
    out_t r;
    r              = '0;
    r.is_event     = is_ev;
    if (is_ev) begin
      r.out_kind     = e.kind;
      r.out_slot     = e.slot;
      r.out_pitch    = e.pitch;
      r.out_volume   = e.volume;
      r.out_duration = e.duration;
      r.out_aux      = e.aux;
      r.out_lane     = e.lane;
    end
    r.status       = st;
    r.stored_count = cnt;
    r.last         = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/elr_fifo.sv -----
// Short command queue between the front end and the execution engine.
// Depends on elr_pkg for the command type and queue depth.
`default_nettype none

module elr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire elr_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output elr_pkg::cmd_t      head_o,
  output logic               empty_o
);

  localparam int unsigned Depth = elr_pkg::QueueDepth;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW    = $clog2(Depth + 1);

  elr_pkg::cmd_t buf_q [Depth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == NW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rd_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
    return n;
  endfunction

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wrap_inc(wr_q);
    end
    if (pop_i) begin
      rd_d = wrap_inc(rd_q);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/elr_front.sv -----
// Front end: takes input transactions, holds the arm register, decodes commands.
// Depends on elr_pkg; feeds elr_fifo.
`default_nettype none

module elr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire elr_pkg::in_t  in_data_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output elr_pkg::cmd_t      push_data_o
);

  logic armed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else if (cfg_we_i) begin
      armed_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_data_o.evt.pos      = in_data_i.position;
    push_data_o.evt.kind     = in_data_i.kind;
    push_data_o.evt.slot     = in_data_i.slot;
    push_data_o.evt.pitch    = in_data_i.pitch;
    push_data_o.evt.volume   = in_data_i.volume;
    push_data_o.evt.duration = in_data_i.duration;
    push_data_o.evt.aux      = in_data_i.aux;
    push_data_o.evt.lane     = in_data_i.lane;
    case (in_data_i.command)
      elr_pkg::CMD_RECORD: begin
        // arm check resolved here; the store-full check needs the count
        push_data_o.op = armed_q ? elr_pkg::OP_RECORD : elr_pkg::OP_REJECT;
      end
      elr_pkg::CMD_TICK:       push_data_o.op = elr_pkg::OP_TICK;
      elr_pkg::CMD_CLEAR_LANE: push_data_o.op = elr_pkg::OP_CLEAR_LANE;
      elr_pkg::CMD_CLEAR_ALL:  push_data_o.op = elr_pkg::OP_CLEAR_ALL;
      default:                 push_data_o.op = elr_pkg::OP_CLEAR_ALL;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/elr_back.sv -----
// Execution engine: event store, replay scan, lane compaction, output register.
// Depends on elr_pkg and event_loop_recorder_defines.svh; pops from elr_fifo.
`default_nettype none
`include "event_loop_recorder_defines.svh"

module elr_back #(
  parameter int unsigned EVENT_DEPTH = elr_pkg::EventDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire elr_pkg::cmd_t q_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output elr_pkg::out_t      out_data_o
);

  localparam int unsigned AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(EVENT_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TRD  = 6'b000010,
    S_TEV  = 6'b000100,
    S_CRD  = 6'b001000,
    S_CEV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d, idx_nxt;
  logic [CW-1:0]   wp_q, wp_d, wp_nxt;
  logic [14:0]     prev_q, prev_d;
  elr_pkg::cmd_t   cur_q, cur_d;
  elr_pkg::event_t pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  elr_pkg::out_t   res_q, res_d;
  logic            out_valid_q, out_valid_d;
  elr_pkg::out_t   out_q, out_d;

  elr_pkg::event_t mem_q [EVENT_DEPTH];
  elr_pkg::event_t rd_q;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  elr_pkg::event_t wr_data;

  logic            out_free;
  logic            wrap, hit, keep;
  logic [6:0]      cnt7;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cnt7        = 7'(count_q);
  assign idx_nxt     = idx_q + CW'(1);

  // window (prev, pos], wrapping past the loop end when pos moved backwards
  assign wrap = cur_q.evt.pos < prev_q;
  assign hit  = wrap ? (rd_q.pos > prev_q || rd_q.pos <= cur_q.evt.pos)
                     : (rd_q.pos > prev_q && rd_q.pos <= cur_q.evt.pos);
  assign keep   = rd_q.lane != cur_q.evt.lane;
  assign wp_nxt = wp_q + CW'(keep);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wp_d        = wp_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = wp_q[AW-1:0];
    wr_data     = rd_q;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o    = 1'b1;
          cur_d    = q_head_i;
          idx_d    = '0;
          wp_d     = '0;
          pend_v_d = 1'b0;
          state_d  = S_EMIT;
          res_d    = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_DONE, cnt7, 1'b1);
          case (q_head_i.op)
            elr_pkg::OP_RECORD: begin
              if (count_q < CW'(EVENT_DEPTH)) begin
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                wr_data = q_head_i.evt;
                count_d = count_q + CW'(1);
                res_d   = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_DONE,
                                             7'(count_d), 1'b1);
              end else begin
                res_d = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_FULL, cnt7, 1'b1);
              end
            end
            elr_pkg::OP_REJECT: begin
              res_d = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_NOT_ARMED, cnt7, 1'b1);
            end
            elr_pkg::OP_TICK: begin
              if (count_q == '0) begin
                prev_d = q_head_i.evt.pos;
              end else begin
                state_d = S_TRD;
              end
            end
            elr_pkg::OP_CLEAR_LANE: begin
              if (count_q != '0) begin
                state_d = S_CRD;
              end
            end
            elr_pkg::OP_CLEAR_ALL: begin
              count_d = '0;
              res_d   = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_DONE, 7'd0, 1'b1);
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_TRD: begin
        state_d = S_TEV;
      end

      S_TEV: begin
        // a hit is held back one step so the final one can carry last
        if (!(hit && pend_v_q && !out_free)) begin
          if (hit && pend_v_q) begin
            out_valid_d = 1'b1;
            out_d = elr_pkg::mk_result(1'b1, pend_q, elr_pkg::ST_DONE, cnt7, 1'b0);
          end
          if (hit) begin
            pend_d   = rd_q;
            pend_v_d = 1'b1;
          end
          if (idx_nxt == count_q) begin
            prev_d  = cur_q.evt.pos;
            state_d = S_EMIT;
            if (hit) begin
              res_d = elr_pkg::mk_result(1'b1, rd_q, elr_pkg::ST_DONE, cnt7, 1'b1);
            end else if (pend_v_q) begin
              res_d = elr_pkg::mk_result(1'b1, pend_q, elr_pkg::ST_DONE, cnt7, 1'b1);
            end else begin
              res_d = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_DONE, cnt7, 1'b1);
            end
          end else begin
            idx_d   = idx_nxt;
            state_d = S_TRD;
          end
        end
      end

      S_CRD: begin
        state_d = S_CEV;
      end

      S_CEV: begin
        if (keep) begin
          wr_en   = 1'b1;
          wr_addr = wp_q[AW-1:0];
          wr_data = rd_q;
        end
        if (idx_nxt == count_q) begin
          count_d = wp_nxt;
          res_d   = elr_pkg::mk_result(1'b0, '0, elr_pkg::ST_DONE, 7'(wp_nxt), 1'b1);
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_nxt;
          wp_d    = wp_nxt;
          state_d = S_CRD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      wp_q        <= '0;
      prev_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      wp_q        <= wp_d;
      prev_q      <= prev_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // event store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  `ELR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(EVENT_DEPTH), "event count overflow")
  `ELR_ASSERT(a_compact_order, clk_i, rst_ni, (state_q == S_CEV) |-> (wp_q <= idx_q), "compaction write passed read")
  `ELR_ASSERT(a_event_status, clk_i, rst_ni, (out_valid_q && out_q.is_event) |-> (out_q.status == elr_pkg::ST_DONE), "replayed event with nonzero status")
  `ELR_ASSERT_ALWAYS(a_single_last, clk_i, (out_valid_q && !out_q.is_event) |-> out_q.last, "non-event result without last")

endmodule

`default_nettype wire

// ----- hw/rtl/event_loop_recorder.sv -----
// Loop event recorder: records timestamped events and replays them on ticks.
//
// Input channel: in_valid_i / in_stall_o / in_data_i, one command per transaction
// (record, tick, clear lane, clear all). Output channel: out_valid_o / out_stall_i /
// out_data_o. A transaction moves on an edge with valid high and stall low.
// Config: cfg_we_i writes cfg_wdata_i into the record-arm bit; write only while idle.
// Every command gives one result, except a tick with hits, which gives one per
// replayed event in stored order, last set on the final one.
// Commands pass through a two-entry queue into the execution engine, so input
// is taken while the engine works or a result waits on a stalled receiver.
// Record and clear-all finish in the idle state and go straight to emit. Tick and
// clear lane walk the store through its single registered read port, with a read step
// and an evaluate step per stored event.
// Reset empties the store (count to zero), clears the previous position and the
// arm bit; no clearing pass is needed. A stalled output holds its result and the
// scan pauses when a further hit finds the output register still occupied.
// Depends on elr_pkg, elr_front, elr_fifo, elr_back.
`default_nettype none

module event_loop_recorder #(
  parameter int unsigned EVENT_DEPTH = elr_pkg::EventDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire elr_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output elr_pkg::out_t      out_data_o
);

  logic          push, q_full, pop, q_empty;
  elr_pkg::cmd_t push_data, q_head;

  elr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  elr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  elr_back #(
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- test/event_loop_recorder_test.sv -----
// Self-checking testbench for event_loop_recorder: record, tick replay, lane and full clears.
// Drives random and directed commands and checks each result against a built-in predictor.
// Depends on elr_pkg and the event_loop_recorder RTL.
`timescale 1ns / 1ps

module event_loop_recorder_test;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 200;
  localparam int IDLE_PCT      = 37;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_ARM,
    STEP_DRAIN
  } step_e;

  typedef struct {
    step_e        kind;
    elr_pkg::in_t cmd;
    logic         arm;
  } plan_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic          cfg_wdata_i = 1'b0;
  logic          in_valid_i  = 1'b0;
  elr_pkg::in_t  in_data_i   = '0;
  logic          out_stall_i = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  elr_pkg::out_t out_data_o;

  event_loop_recorder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus plan and generator state
  plan_t       plan_q[$];
  int          n_items     = 0;
  logic [14:0] plan_pos    = '0;
  int          plan_count  = 0;
  logic        plan_armed  = 1'b0;

  // Predictor state, mirrors the recorder
  elr_pkg::event_t loop_store[elr_pkg::EventDepth];
  int unsigned     loop_count  = 0;
  logic [14:0]     prev_pos    = '0;
  logic            rec_armed   = 1'b0;
  elr_pkg::out_t   due_results[$];

  int   outstanding = 0;
  int   errors      = 0;
  int   sent_count  = 0;
  int   settle      = 0;
  logic calm        = 1'b0;
  logic stim_done   = 1'b0;

  function automatic elr_pkg::in_t event_cmd(input elr_pkg::command_e op,
                                             input logic [14:0] pos,
                                             input logic [1:0] kind, input logic [3:0] slot,
                                             input logic [14:0] pitch, input logic [2:0] vol,
                                             input logic [11:0] dur, input logic [2:0] aux,
                                             input logic [2:0] lane);
    return {op, pos, kind, slot, pitch, vol, dur, aux, lane};
  endfunction

  function automatic elr_pkg::in_t make_cmd(input elr_pkg::command_e op,
                                            input logic [14:0] pos);
    return event_cmd(op, pos, 2'($urandom), 4'($urandom), 15'($urandom), 3'($urandom),
                     12'($urandom), 3'($urandom), 3'($urandom));
  endfunction

  task automatic add_item(input elr_pkg::in_t c);
    plan_t p;
    p.kind = STEP_ITEM;
    p.cmd  = c;
    p.arm  = 1'b0;
    plan_q.push_back(p);
    n_items++;
  endtask

  task automatic add_arm(input logic v);
    plan_t p;
    p.kind = STEP_ARM;
    p.cmd  = '0;
    p.arm  = v;
    plan_q.push_back(p);
    plan_armed = v;
  endtask

  task automatic add_drain();
    plan_t p;
    p.kind = STEP_DRAIN;
    p.cmd  = '0;
    p.arm  = 1'b0;
    plan_q.push_back(p);
  endtask

  task automatic add_lane_clear(input logic [2:0] lane);
    elr_pkg::in_t c;
    c      = make_cmd(elr_pkg::CMD_CLEAR_LANE, 15'($urandom));
    c.lane = lane;
    add_item(c);
  endtask

  // Well-formed round: a few records, ticks moving forward through the loop,
  // an occasional clear, and now and then a fully random command.
  task automatic plan_round();
    int n;
    int i;
    if ($urandom_range(9) == 0) add_arm($urandom_range(4) != 0);
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      add_item(make_cmd(elr_pkg::CMD_RECORD, 15'($urandom)));
      if (plan_armed && plan_count < elr_pkg::EventDepth) plan_count++;
    end
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) plan_pos = 15'($urandom);
      else plan_pos = plan_pos + 15'($urandom_range(0, 'h2000));
      add_item(make_cmd(elr_pkg::CMD_TICK, plan_pos));
    end
    if (plan_count > 48 || $urandom_range(3) == 0) begin
      if ($urandom_range(4) == 0) begin
        add_item(make_cmd(elr_pkg::CMD_CLEAR_ALL, 15'($urandom)));
        plan_count = 0;
      end else begin
        add_lane_clear(3'($urandom));
        plan_count = plan_count * 7 / 8;
      end
    end
    if ($urandom_range(9) == 0)
      add_item(make_cmd(elr_pkg::command_e'($urandom_range(3)), 15'($urandom)));
  endtask

  initial begin : build_plan
    int i;
    // directed
    add_arm(1'b0);
    add_item(event_cmd(elr_pkg::CMD_RECORD, 15'h7FFF, 2'd3, 4'hF, 15'h7FFF, 3'd7, 12'hFFF,
                       3'd7, 3'd7));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h0000));
    add_arm(1'b1);
    add_item(event_cmd(elr_pkg::CMD_RECORD, 15'h0000, 2'd0, 4'h0, 15'h0000, 3'd0, 12'h000,
                       3'd0, 3'd0));
    add_item(event_cmd(elr_pkg::CMD_RECORD, 15'h7FFF, 2'd3, 4'hF, 15'h7FFF, 3'd7, 12'hFFF,
                       3'd7, 3'd7));
    add_item(event_cmd(elr_pkg::CMD_RECORD, 15'h1000, 2'd1, 4'h5, 15'h3C00, 3'd4, 12'd250,
                       3'd2, 3'd2));
    add_item(event_cmd(elr_pkg::CMD_RECORD, 15'h2000, 2'd2, 4'hA, 15'h4080, 3'd1, 12'd0,
                       3'd5, 3'd2));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h1000));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h1000));   // empty window
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h7FFF));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h0800));   // wraps past loop end
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h0800));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h0000));   // wrap catches everything
    add_lane_clear(3'd2);
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h7FFF));
    add_lane_clear(3'd5);
    add_item(make_cmd(elr_pkg::CMD_CLEAR_ALL, 15'h0000));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h0000));
    plan_pos = 15'h0000;

    while (n_items < 100) plan_round();

    // fill the store past capacity, then hit it while disarmed
    add_drain();
    add_arm(1'b1);
    add_item(make_cmd(elr_pkg::CMD_CLEAR_ALL, 15'($urandom)));
    for (i = 0; i < elr_pkg::EventDepth + 2; i++)
      add_item(make_cmd(elr_pkg::CMD_RECORD, 15'($urandom)));
    add_arm(1'b0);
    add_item(make_cmd(elr_pkg::CMD_RECORD, 15'($urandom)));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h4000));
    add_item(make_cmd(elr_pkg::CMD_TICK, 15'h3FFF));
    add_lane_clear(3'($urandom));
    add_arm(1'b1);
    plan_pos   = 15'h3FFF;
    plan_count = 56;

    while (n_items < 250) plan_round();
  end

  // Predictor: one command in, its results appended to due_results.
  task automatic recorder_step(input elr_pkg::in_t c);
    elr_pkg::out_t   r;
    elr_pkg::out_t   held;
    logic            have_hit;
    logic            wrap;
    logic            hit;
    elr_pkg::event_t e;
    int unsigned     i;
    int unsigned     w;
    r = '0;
    case (elr_pkg::command_e'(c.command))
      elr_pkg::CMD_RECORD: begin
        if (!rec_armed) begin
          r.status = elr_pkg::ST_NOT_ARMED;
        end else if (loop_count >= elr_pkg::EventDepth) begin
          r.status = elr_pkg::ST_FULL;
        end else begin
          loop_store[loop_count] = {c.position, c.kind, c.slot, c.pitch, c.volume,
                                    c.duration, c.aux, c.lane};
          loop_count++;
        end
      end
      elr_pkg::CMD_TICK: begin
        wrap     = c.position < prev_pos;
        have_hit = 1'b0;
        held     = '0;
        for (i = 0; i < loop_count; i++) begin
          e   = loop_store[i];
          hit = wrap ? (e.pos > prev_pos || e.pos <= c.position)
                     : (e.pos > prev_pos && e.pos <= c.position);
          if (hit) begin
            if (have_hit) due_results.push_back(held);
            held              = '0;
            held.is_event     = 1'b1;
            held.out_kind     = e.kind;
            held.out_slot     = e.slot;
            held.out_pitch    = e.pitch;
            held.out_volume   = e.volume;
            held.out_duration = e.duration;
            held.out_aux      = e.aux;
            held.out_lane     = e.lane;
            held.status       = elr_pkg::ST_DONE;
            held.stored_count = 7'(loop_count);
            have_hit          = 1'b1;
          end
        end
        prev_pos = c.position;
        if (have_hit) begin
          held.last = 1'b1;
          due_results.push_back(held);
          return;
        end
      end
      elr_pkg::CMD_CLEAR_LANE: begin
        w = 0;
        for (i = 0; i < loop_count; i++) begin
          if (loop_store[i].lane != c.lane) begin
            loop_store[w] = loop_store[i];
            w++;
          end
        end
        loop_count = w;
      end
      default: loop_count = 0;
    endcase
    r.stored_count = 7'(loop_count);
    r.last         = 1'b1;
    due_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 100)
        $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Driver: holds each transaction until accepted, waits for quiet before arm writes.
  always @(posedge clk_i) begin : drive
    plan_t step;
    logic  take;
    logic  valid_next;
    logic  we_next;
    if (rst_ni) begin
      take = in_valid_i && !in_stall_o;
      if (take) sent_count++;
      if (outstanding == 0 && !in_valid_i && !cfg_we_i) settle++;
      else settle = 0;
      valid_next = in_valid_i && !take;
      we_next    = 1'b0;
      if (!valid_next) begin
        if (plan_q.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          step = plan_q[0];
          case (step.kind)
            STEP_ITEM: begin
              if (calm || $urandom_range(99) >= IDLE_PCT) begin
                in_data_i  <= step.cmd;
                valid_next = 1'b1;
                plan_q.delete(0);
              end
            end
            STEP_ARM: begin
              if (settle >= SETTLE_CYCLES) begin
                we_next     = 1'b1;
                cfg_wdata_i <= step.arm;
                plan_q.delete(0);
              end
            end
            default: begin
              if (settle >= SETTLE_CYCLES) plan_q.delete(0);
            end
          endcase
        end
      end
      in_valid_i <= valid_next;
      cfg_we_i   <= we_next;
      calm       <= (sent_count >= 110 && sent_count < 170);
    end
  end

  always @(posedge clk_i) begin : receiver_stall
    if (rst_ni) out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: tracks the arm bit, predicts accepted commands, checks results.
  always @(posedge clk_i) begin : watch
    elr_pkg::out_t want;
    if (rst_ni) begin
      if (cfg_we_i) rec_armed = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) recorder_step(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %h", $time, out_data_o);
        end else begin
          want = due_results.pop_front();
          compare_field("is_event", want.is_event, out_data_o.is_event);
          compare_field("out_kind", want.out_kind, out_data_o.out_kind);
          compare_field("out_slot", want.out_slot, out_data_o.out_slot);
          compare_field("out_pitch", want.out_pitch, out_data_o.out_pitch);
          compare_field("out_volume", want.out_volume, out_data_o.out_volume);
          compare_field("out_duration", want.out_duration, out_data_o.out_duration);
          compare_field("out_aux", want.out_aux, out_data_o.out_aux);
          compare_field("out_lane", want.out_lane, out_data_o.out_lane);
          compare_field("status", want.status, out_data_o.status);
          compare_field("stored_count", want.stored_count, out_data_o.stored_count);
          compare_field("last", want.last, out_data_o.last);
        end
      end
      outstanding <= due_results.size();
    end
  end

  initial begin : wrap_up
    wait (stim_done);
    @(posedge clk_i);
    #1;
    while (outstanding != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    #1;
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
